/* sv/stmf_pkg.sv */
// shared constants and types for the scaled trimmed-mean filter
`timescale 1ns / 1ps
`default_nettype none

package stmf_pkg;

  localparam int DEF_WINDOW   = 8;
  localparam int DEF_CHANNELS = 4;

  localparam int CH_W    = 2;
  localparam int RAW_W   = 16;
  localparam int MULT_W  = 16;
  localparam int DIV_W   = 16;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // dividend width of the shared divider for the default window
  localparam int DEF_QW = 38;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_MULT    = 1'b0,
    REG_SCALE_DIVISOR = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

/* sv/stmf_div.sv */
// unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps
`default_nettype none

module stmf_div #(
  parameter int QW = stmf_pkg::DEF_QW
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [QW-1:0]              dividend,
  input  wire logic [stmf_pkg::DIV_W-1:0] divisor,
  output logic                            done,
  output logic [QW-1:0]                   quotient
);
  import stmf_pkg::*;

  localparam int STEPS = QW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsr_r;
  logic [QW-1:0]    quo_r;

  logic [DIV_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [DIV_W:0]   s1, s2;

  always_comb begin
    t1  = {rem_r, quo_r[QW-1]};
    ge1 = t1 >= {1'b0, dsr_r};
    s1  = ge1 ? t1 - {1'b0, dsr_r} : t1;
    t2  = {s1[DIV_W-1:0], quo_r[QW-2]};
    ge2 = t2 >= {1'b0, dsr_r};
    s2  = ge2 ? t2 - {1'b0, dsr_r} : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= s2[DIV_W-1:0];
        quo_r <= {quo_r[QW-3:0], ge1, ge2};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* sv/scaled_trimmed_mean_filter.sv */
// top level: per-channel scaled olympic moving average over a ring memory
//
//  port group | dir | handshake         | contents
//  in_*       | in  | in_valid/in_stall | channel, raw sample, skip flag
//  out_*      | out | out_valid/out_stall | channel, filtered value
//  cfg_*      | in  | cfg_wr_en         | scale multiplier, scale divisor
//
// one word at a time: each word takes up to two passes through the shared
// two-bit-per-cycle divider (scaling, then the trimmed mean) and a one-read-per-cycle
// scan of the channel's ring memory.
// synchronous reset clears fill counts and ring positions; no memory clearing pass.
// a finished word waits in the output register while the next input word is taken.
`timescale 1ns / 1ps
`default_nettype none

module scaled_trimmed_mean_filter #(
  parameter int WINDOW   = stmf_pkg::DEF_WINDOW,
  parameter int CHANNELS = stmf_pkg::DEF_CHANNELS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [stmf_pkg::CH_W-1:0]      in_channel,
  input  wire logic [stmf_pkg::RAW_W-1:0]     in_raw_sample,
  input  wire logic                           in_skip_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [stmf_pkg::CH_W-1:0]           out_channel,
  output logic signed [stmf_pkg::VAL_W-1:0]   out_filtered_value,
  input  wire logic                           cfg_wr_en,
  input  wire logic [stmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stmf_pkg::CFG_W-1:0]     cfg_wdata
);
  import stmf_pkg::*;

  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW    = VAL_W + FW + 1;
  localparam int QW    = SW + (SW % 2);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SCL, S_SDIV, S_WR, S_SCAN, S_TRIM, S_FIN
  } state_t;

  state_t state_r;
  logic   mdiv_r;

  // configuration
  logic signed [MULT_W-1:0] mult_r;
  logic [DIV_W-1:0]         divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r    <= MULT_W'(1);
      divisor_r <= DIV_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SCALE_MULT:    mult_r    <= cfg_wdata[MULT_W-1:0];
        REG_SCALE_DIVISOR: divisor_r <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // per-channel ring bookkeeping
  logic [PW-1:0] pos_r  [CHANNELS];
  logic [FW-1:0] fill_r [CHANNELS];

  // item registers
  logic [CH_W-1:0]         ch_r;
  logic [RAW_W-1:0]        raw_r;
  logic                    skip_r;
  logic signed [VAL_W:0]   prod_r;
  logic signed [VAL_W-1:0] scaled_r;
  logic signed [VAL_W-1:0] val_r;
  logic                    neg_r;

  // scan registers
  logic [FW-1:0]           iss_r;
  logic                    rv_r;
  logic [PW-1:0]           rp_r;
  logic                    found_r;
  logic signed [VAL_W-1:0] lo_r, hi_r;
  logic [PW-1:0]           lo_idx_r, hi_idx_r;
  logic signed [SW-1:0]    sum_r;

  // output register
  logic                    out_valid_r;
  logic [CH_W-1:0]         out_ch_r;
  logic signed [VAL_W-1:0] out_val_r;

  // divider
  logic             div_start_r;
  logic [QW-1:0]    div_dvd_r;
  logic [DIV_W-1:0] div_dsr_r;
  logic             div_done;
  logic [QW-1:0]    div_quo;

  stmf_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ring memory
  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  logic                    ch_ok;
  logic [CIW-1:0]          ch_idx;
  logic [AW-1:0]           base;
  logic [FW-1:0]           fill_cur;
  logic                    mem_we, mem_re;
  logic [AW-1:0]           waddr, raddr;
  logic [VAL_W:0]          pmag;
  logic [VAL_W-1:0]        q32;
  logic signed [VAL_W-1:0] qval;
  logic signed [SW-1:0]    lo_ext, hi_ext, tsum;
  logic [SW-1:0]           tmag;
  logic                    same_idx;
  logic [DIV_W-1:0]        tcnt;
  logic                    out_load;

  always_comb begin
    ch_ok    = int'(ch_r) < CHANNELS;
    ch_idx   = CIW'(ch_r);
    base     = AW'(int'(ch_idx) * WINDOW);
    fill_cur = fill_r[ch_idx];
    mem_we   = state_r == S_WR;
    mem_re   = (state_r == S_SCAN) && (iss_r < fill_cur);
    waddr    = base + AW'(pos_r[ch_idx]);
    raddr    = base + AW'(iss_r);
    pmag     = prod_r[VAL_W] ? -prod_r : prod_r;
    q32      = div_quo[VAL_W-1:0];
    qval     = neg_r ? -$signed(q32) : $signed(q32);
    lo_ext   = {{(SW-VAL_W){lo_r[VAL_W-1]}}, lo_r};
    hi_ext   = {{(SW-VAL_W){hi_r[VAL_W-1]}}, hi_r};
    same_idx = lo_idx_r == hi_idx_r;
    tsum     = same_idx ? sum_r - lo_ext : sum_r - lo_ext - hi_ext;
    tmag     = tsum[SW-1] ? -tsum : tsum;
    tcnt     = DIV_W'(int'(fill_cur) - (same_idx ? 1 : 2));
    out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= scaled_r;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mdiv_r      <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      rv_r        <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]  <= '0;
        fill_r[c] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_ch_r    <= ch_r;
        out_val_r   <= val_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ch_r    <= in_channel;
            raw_r   <= in_raw_sample;
            skip_r  <= in_skip_sample;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= $signed({1'b0, raw_r}) * mult_r;
          iss_r   <= '0;
          found_r <= 1'b0;
          rv_r    <= 1'b0;
          priority if (!ch_ok) begin
            val_r   <= '0;
            state_r <= S_FIN;
          end else if (skip_r) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_SCL;
          end
        end
        S_SCL: begin
          if (divisor_r == '0) begin
            scaled_r <= '0;
            state_r  <= S_WR;
          end else begin
            div_start_r <= 1'b1;
            div_dvd_r   <= QW'(pmag[VAL_W-1:0]);
            div_dsr_r   <= divisor_r;
            neg_r       <= prod_r[VAL_W];
            mdiv_r      <= 1'b0;
            state_r     <= S_SDIV;
          end
        end
        S_SDIV: begin
          div_start_r <= 1'b0;
          if (div_done) begin
            if (mdiv_r) begin
              val_r   <= qval;
              state_r <= S_FIN;
            end else begin
              scaled_r <= qval;
              state_r  <= S_WR;
            end
          end
        end
        S_WR: begin
          pos_r[ch_idx] <= (pos_r[ch_idx] == PW'(WINDOW - 1)) ? '0
                           : pos_r[ch_idx] + PW'(1);
          if (fill_r[ch_idx] < FW'(WINDOW)) begin
            fill_r[ch_idx] <= fill_r[ch_idx] + FW'(1);
          end
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (mem_re) begin
            iss_r <= iss_r + FW'(1);
            rp_r  <= PW'(iss_r);
            rv_r  <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          if (rv_r) begin
            if (!found_r) begin
              found_r  <= 1'b1;
              lo_r     <= rdata_r;
              hi_r     <= rdata_r;
              lo_idx_r <= rp_r;
              hi_idx_r <= rp_r;
              sum_r    <= {{(SW-VAL_W){rdata_r[VAL_W-1]}}, rdata_r};
            end else begin
              if (rdata_r < lo_r) begin
                lo_r     <= rdata_r;
                lo_idx_r <= rp_r;
              end
              if (rdata_r > hi_r) begin
                hi_r     <= rdata_r;
                hi_idx_r <= rp_r;
              end
              sum_r <= sum_r + {{(SW-VAL_W){rdata_r[VAL_W-1]}}, rdata_r};
            end
          end
          if (!mem_re && !rv_r) begin
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (!found_r || tcnt == '0) begin
            val_r   <= '0;
            state_r <= S_FIN;
          end else begin
            div_start_r <= 1'b1;
            div_dvd_r   <= QW'(tmag);
            div_dsr_r   <= tcnt;
            neg_r       <= tsum[SW-1];
            mdiv_r      <= 1'b1;
            state_r     <= S_SDIV;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_channel        = out_ch_r;
  assign out_filtered_value = out_val_r;

endmodule

`default_nettype wire
